@@ hdl/nfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_pkg
// Constants and types shared by the NEC frame decoder and its checker.
// ----------------------------------------------------------------------------
package nfd_pkg;

	localparam int MAX_KEPT_SYMBOLS_DEF  = 160;
	localparam int MAX_FRAME_SYMBOLS_DEF = 192;
	localparam int MAX_CODE_BITS_DEF     = 64;

	localparam int DUR_W    = 15;
	localparam int CNT_W    = 8;
	localparam int BITS_W   = 7;
	localparam int CODE_W   = 64;
	localparam int CFG_IDX_W = 3;

	// longest frame that is still rejected as too short, and least symbols past the leader
	localparam int MIN_FRAME_REJECT = 20;
	localparam int LEADER_GAP       = 16;

	localparam logic [DUR_W-1:0]  LEADER_MIN_RST    = 15'd7000;
	localparam logic [DUR_W-1:0]  LEADER_MAX_RST    = 15'd11000;
	localparam logic [DUR_W-1:0]  MARK_MIN_RST      = 15'd300;
	localparam logic [DUR_W-1:0]  MARK_MAX_RST      = 15'd900;
	localparam logic [DUR_W-1:0]  SPACE_MIN_RST     = 15'd200;
	localparam logic [DUR_W-1:0]  ONE_THRESHOLD_RST = 15'd1000;
	localparam logic [BITS_W-1:0] MIN_BITS_RST      = 7'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEADER_MIN    = 3'd0,
		CFG_LEADER_MAX    = 3'd1,
		CFG_MARK_MIN      = 3'd2,
		CFG_MARK_MAX      = 3'd3,
		CFG_SPACE_MIN     = 3'd4,
		CFG_ONE_THRESHOLD = 3'd5,
		CFG_MIN_BITS      = 3'd6
	} cfg_idx_t;

endpackage
`default_nettype wire

@@ hdl/nec_frame_decoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nec_frame_decoder_top
// Path: after the transfer of its last symbol, a frame result goes through
// the input register, then the result register.
// Throughput: one symbol per cycle; a symbol without a result never waits, and
// a last symbol waits in the input register only while an earlier result stalls.
// Reset: asynchronous, active low; clears frame state and restores the
// default timing windows.
// ----------------------------------------------------------------------------
module nec_frame_decoder_top #(
	parameter int MAX_KEPT_SYMBOLS  = nfd_pkg::MAX_KEPT_SYMBOLS_DEF,
	parameter int MAX_FRAME_SYMBOLS = nfd_pkg::MAX_FRAME_SYMBOLS_DEF,
	parameter int MAX_CODE_BITS     = nfd_pkg::MAX_CODE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_wr_en,
	input  wire logic [nfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nfd_pkg::DUR_W-1:0]     cfg_data,
	// symbol input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [nfd_pkg::DUR_W-1:0]     mark_duration,
	input  wire logic [nfd_pkg::DUR_W-1:0]     space_duration,
	input  wire logic                          last_symbol,
	// frame result
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               frame_ok,
	output logic                               nec_ok,
	output logic                               raw_only,
	output logic [nfd_pkg::CODE_W-1:0]         code_value,
	output logic [nfd_pkg::BITS_W-1:0]         bit_count
);

	localparam logic [nfd_pkg::CNT_W-1:0]  KEPT_LIM  = nfd_pkg::CNT_W'(MAX_KEPT_SYMBOLS);
	localparam logic [nfd_pkg::CNT_W-1:0]  FRAME_LIM = nfd_pkg::CNT_W'(MAX_FRAME_SYMBOLS);
	localparam logic [nfd_pkg::CNT_W-1:0]  SHORT_LIM =
		nfd_pkg::CNT_W'(nfd_pkg::MIN_FRAME_REJECT);
	localparam logic [nfd_pkg::CNT_W:0]    GAP       =
		(nfd_pkg::CNT_W+1)'(nfd_pkg::LEADER_GAP);
	localparam logic [nfd_pkg::BITS_W-1:0] BITS_LIM  = nfd_pkg::BITS_W'(MAX_CODE_BITS);
	localparam logic [nfd_pkg::CNT_W-1:0]  CNT_SAT   = '1;

	// configuration registers
	logic [nfd_pkg::DUR_W-1:0]  leader_min_q, leader_max_q, mark_min_q, mark_max_q;
	logic [nfd_pkg::DUR_W-1:0]  space_min_q, one_threshold_q;
	logic [nfd_pkg::BITS_W-1:0] min_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_min_q    <= nfd_pkg::LEADER_MIN_RST;
			leader_max_q    <= nfd_pkg::LEADER_MAX_RST;
			mark_min_q      <= nfd_pkg::MARK_MIN_RST;
			mark_max_q      <= nfd_pkg::MARK_MAX_RST;
			space_min_q     <= nfd_pkg::SPACE_MIN_RST;
			one_threshold_q <= nfd_pkg::ONE_THRESHOLD_RST;
			min_bits_q      <= nfd_pkg::MIN_BITS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nfd_pkg::CFG_LEADER_MIN:    leader_min_q    <= cfg_data;
				nfd_pkg::CFG_LEADER_MAX:    leader_max_q    <= cfg_data;
				nfd_pkg::CFG_MARK_MIN:      mark_min_q      <= cfg_data;
				nfd_pkg::CFG_MARK_MAX:      mark_max_q      <= cfg_data;
				nfd_pkg::CFG_SPACE_MIN:     space_min_q     <= cfg_data;
				nfd_pkg::CFG_ONE_THRESHOLD: one_threshold_q <= cfg_data;
				nfd_pkg::CFG_MIN_BITS:      min_bits_q      <= cfg_data[nfd_pkg::BITS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                      valid_s1;
	logic [nfd_pkg::DUR_W-1:0] mark_s1, space_s1;
	logic                      last_s1;
	logic                      advance;
	logic                      out_valid_q;

	// a symbol without a result never waits on the result register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mark_s1  <= mark_duration;
			space_s1 <= space_duration;
			last_s1  <= last_symbol;
		end
	end

	// frame state
	logic [nfd_pkg::CNT_W-1:0]  cnt_q, lpos_q;
	logic                       leader_q, collect_q;
	logic [MAX_CODE_BITS-1:0]   acc_q;
	logic [nfd_pkg::BITS_W-1:0] bits_q;

	logic [nfd_pkg::CNT_W-1:0]  cnt_d, lpos_d, kept;
	logic                       leader_d, collect_d;
	logic [MAX_CODE_BITS-1:0]   acc_d;
	logic [nfd_pkg::BITS_W-1:0] bits_d;
	logic                       fok, nec;

	always_comb begin
		cnt_d     = (cnt_q == CNT_SAT) ? cnt_q : cnt_q + 1'b1;
		lpos_d    = lpos_q;
		leader_d  = leader_q;
		collect_d = collect_q;
		acc_d     = acc_q;
		bits_d    = bits_q;
		if (cnt_q < KEPT_LIM) begin
			if (!leader_q) begin
				if (mark_s1 > leader_min_q && mark_s1 < leader_max_q) begin
					leader_d  = 1'b1;
					lpos_d    = cnt_q;
					collect_d = 1'b1;
				end
			end else if (collect_q) begin
				if (mark_s1 >= mark_min_q && mark_s1 <= mark_max_q &&
				    space_s1 >= space_min_q && bits_q < BITS_LIM) begin
					acc_d  = (acc_q << 1) | MAX_CODE_BITS'(space_s1 > one_threshold_q);
					bits_d = bits_q + 1'b1;
				end else begin
					collect_d = 1'b0;
				end
			end
		end
		kept = (cnt_d > KEPT_LIM) ? KEPT_LIM : cnt_d;
		fok  = (cnt_d > SHORT_LIM) && (cnt_d <= FRAME_LIM);
		nec  = fok && leader_d && ({1'b0, kept} > ({1'b0, lpos_d} + GAP)) &&
		       (bits_d >= min_bits_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			lpos_q    <= '0;
			leader_q  <= 1'b0;
			collect_q <= 1'b0;
			acc_q     <= '0;
			bits_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				cnt_q     <= '0;
				lpos_q    <= '0;
				leader_q  <= 1'b0;
				collect_q <= 1'b0;
				acc_q     <= '0;
				bits_q    <= '0;
			end else begin
				cnt_q     <= cnt_d;
				lpos_q    <= lpos_d;
				leader_q  <= leader_d;
				collect_q <= collect_d;
				acc_q     <= acc_d;
				bits_q    <= bits_d;
			end
		end
	end

	// result register
	logic                       frame_ok_q, nec_ok_q, raw_only_q;
	logic [nfd_pkg::CODE_W-1:0] code_q;
	logic [nfd_pkg::BITS_W-1:0] bit_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			frame_ok_q  <= fok;
			nec_ok_q    <= nec;
			raw_only_q  <= fok && !nec;
			code_q      <= nec ? nfd_pkg::CODE_W'(acc_d) : '0;
			bit_count_q <= nec ? bits_d : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_ok   = frame_ok_q;
	assign nec_ok     = nec_ok_q;
	assign raw_only   = raw_only_q;
	assign code_value = code_q;
	assign bit_count  = bit_count_q;

endmodule
`default_nettype wire

@@ hdl/nfd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nfd_checker
// Port-level checks on the frame result channel of the NEC frame decoder.
// ----------------------------------------------------------------------------
module nfd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic                          frame_ok,
	input wire logic                          nec_ok,
	input wire logic                          raw_only,
	input wire logic [nfd_pkg::CODE_W-1:0]    code_value,
	input wire logic [nfd_pkg::BITS_W-1:0]    bit_count
);

	localparam logic [nfd_pkg::BITS_W-1:0] CODE_BITS = nfd_pkg::BITS_W'(nfd_pkg::CODE_W);

	// a stalled result stays until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a rejected frame carries no decode
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> !nec_ok && !raw_only && code_value == '0 &&
		bit_count == '0)
		else $error("rejected frame carries decode fields");

	// raw_only is exactly a taken frame that failed the NEC test
	a_raw_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> raw_only == (frame_ok && !nec_ok))
		else $error("raw_only inconsistent with frame_ok and nec_ok");

	// code fits the reported bit count
	a_code_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nec_ok |-> bit_count <= CODE_BITS &&
		(bit_count == CODE_BITS || (code_value >> bit_count) == '0))
		else $error("code value wider than bit count");

	// no symbol is held off while the result side is free
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

endmodule

bind nec_frame_decoder_top nfd_checker u_nfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_ok   (frame_ok),
	.nec_ok     (nec_ok),
	.raw_only   (raw_only),
	.code_value (code_value),
	.bit_count  (bit_count)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NEC frame decoder. Symbols are driven with
// random gaps and results are taken with random stall. Each result is compared
// with the output of a frame decoding model kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_HALF        = 5;
	localparam int RST_CYCLES      = 6;
	localparam int IDLE_LIMIT      = 2000;
	localparam int TAIL_CYCLES     = 8;
	localparam int LONG_HOLD       = 200;
	localparam int RAND_SYMBOLS    = 250;
	localparam int MAX_DUR         = 32767;
	localparam int MAX_REPORTS     = 10;
	// index with no register behind it
	localparam logic [nfd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef enum {
		SYM_LEADER,
		SYM_NOT_LEADER,
		SYM_ZERO,
		SYM_ONE,
		SYM_BREAK,
		SYM_NOISE
	} sym_kind_t;

	typedef struct packed {
		logic                       frame_ok;
		logic                       nec_ok;
		logic                       raw_only;
		logic [nfd_pkg::CODE_W-1:0] code;
		logic [nfd_pkg::BITS_W-1:0] nbits;
	} verdict_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [nfd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nfd_pkg::DUR_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [nfd_pkg::DUR_W-1:0]     mark_duration;
	logic [nfd_pkg::DUR_W-1:0]     space_duration;
	logic                          last_symbol;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          frame_ok;
	logic                          nec_ok;
	logic                          raw_only;
	logic [nfd_pkg::CODE_W-1:0]    code_value;
	logic [nfd_pkg::BITS_W-1:0]    bit_count;

	// shadow of the timing windows
	logic [nfd_pkg::DUR_W-1:0]  w_leader_min, w_leader_max, w_mark_min, w_mark_max;
	logic [nfd_pkg::DUR_W-1:0]  w_space_min, w_one_thr;
	logic [nfd_pkg::BITS_W-1:0] w_min_bits;

	// shadow of the frame being decoded
	logic [nfd_pkg::CNT_W-1:0]  f_count;
	logic                       f_leader;
	logic [nfd_pkg::CNT_W-1:0]  f_leader_pos;
	logic                       f_collect;
	logic [nfd_pkg::CODE_W-1:0] f_shift;
	logic [nfd_pkg::BITS_W-1:0] f_bits;

	verdict_t frames_due[$];

	int  n_mismatch = 0;
	int  n_sent = 0;
	int  idle_cycles = 0;
	int  rx_wait = 0;
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;
	logic rx_hold = 1'b0;
	event hold_start;

	nec_frame_decoder_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mark_duration  (mark_duration),
		.space_duration (space_duration),
		.last_symbol    (last_symbol),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_ok       (frame_ok),
		.nec_ok         (nec_ok),
		.raw_only       (raw_only),
		.code_value     (code_value),
		.bit_count      (bit_count)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic void restore_defaults();
		w_leader_min = nfd_pkg::LEADER_MIN_RST;
		w_leader_max = nfd_pkg::LEADER_MAX_RST;
		w_mark_min   = nfd_pkg::MARK_MIN_RST;
		w_mark_max   = nfd_pkg::MARK_MAX_RST;
		w_space_min  = nfd_pkg::SPACE_MIN_RST;
		w_one_thr    = nfd_pkg::ONE_THRESHOLD_RST;
		w_min_bits   = nfd_pkg::MIN_BITS_RST;
	endfunction

	function automatic void clear_frame();
		f_count      = '0;
		f_leader     = 1'b0;
		f_leader_pos = '0;
		f_collect    = 1'b0;
		f_shift      = '0;
		f_bits       = '0;
	endfunction

	function automatic void decode_symbol(input logic [nfd_pkg::DUR_W-1:0] mark,
		input logic [nfd_pkg::DUR_W-1:0] space, input logic last);
		logic [nfd_pkg::CNT_W-1:0] pos;
		int                        kept;
		verdict_t                  v;
		pos = f_count;
		if (f_count != '1)
			f_count = f_count + 1'b1;
		if (int'(pos) < nfd_pkg::MAX_KEPT_SYMBOLS_DEF) begin
			if (!f_leader) begin
				if (mark > w_leader_min && mark < w_leader_max) begin
					f_leader     = 1'b1;
					f_leader_pos = pos;
					f_collect    = 1'b1;
				end
			end else if (f_collect) begin
				if (mark >= w_mark_min && mark <= w_mark_max && space >= w_space_min &&
						int'(f_bits) < nfd_pkg::MAX_CODE_BITS_DEF) begin
					f_shift = {f_shift[nfd_pkg::CODE_W-2:0], space > w_one_thr};
					f_bits  = f_bits + 1'b1;
				end else begin
					f_collect = 1'b0;
				end
			end
		end
		if (last) begin
			kept = (int'(f_count) > nfd_pkg::MAX_KEPT_SYMBOLS_DEF) ?
				nfd_pkg::MAX_KEPT_SYMBOLS_DEF : int'(f_count);
			v = '0;
			v.frame_ok = int'(f_count) > nfd_pkg::MIN_FRAME_REJECT &&
				int'(f_count) <= nfd_pkg::MAX_FRAME_SYMBOLS_DEF;
			v.nec_ok = v.frame_ok && f_leader &&
				kept > int'(f_leader_pos) + nfd_pkg::LEADER_GAP && f_bits >= w_min_bits;
			v.raw_only = v.frame_ok && !v.nec_ok;
			if (v.nec_ok) begin
				v.code  = f_shift;
				v.nbits = f_bits;
			end
			frames_due.push_back(v);
			clear_frame();
		end
	endfunction

	// ---------------------------------------------------------- result side

	always @(posedge clk) begin : rx_pace
		if (out_valid && !out_stall)
			rx_wait = rx_idle_en ? $urandom_range(7, 0) : 0;
		else if (rx_wait > 0)
			rx_wait--;
		out_stall <= rx_hold || (rx_wait > 0);
	end

	// long hold-off, counted here while the sender keeps offering symbols
	initial begin
		forever begin
			@(hold_start);
			@(posedge clk);
			rx_hold <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	function automatic void note_mismatch(input string what, input verdict_t want,
		input verdict_t got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display({"[%0t] %s: exp/act frame_ok %b/%b nec_ok %b/%b raw_only %b/%b",
				" code %h/%h bits %0d/%0d"},
				$realtime, what, want.frame_ok, got.frame_ok, want.nec_ok, got.nec_ok,
				want.raw_only, got.raw_only, want.code, got.code, want.nbits, got.nbits);
	endfunction

	always @(posedge clk) begin : result_check
		verdict_t want;
		verdict_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {frame_ok, nec_ok, raw_only, code_value, bit_count};
			if (frames_due.size() == 0) begin
				note_mismatch("result with nothing expected", '0, got);
			end else begin
				want = frames_due.pop_front();
				if (got !== want)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------- symbol side

	function automatic int pick(input int lo, input int hi);
		if (lo < 0) lo = 0;
		if (hi > MAX_DUR) hi = MAX_DUR;
		if (hi < 0) hi = 0;
		if (lo > MAX_DUR) lo = MAX_DUR;
		return $urandom_range(hi, lo);
	endfunction

	task automatic send_symbol(input int mark, input int space, input logic last);
		int gap;
		gap = tx_idle_en ? $urandom_range(7, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		mark_duration  <= mark[nfd_pkg::DUR_W-1:0];
		space_duration <= space[nfd_pkg::DUR_W-1:0];
		last_symbol    <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer taken at this edge
		decode_symbol(mark[nfd_pkg::DUR_W-1:0], space[nfd_pkg::DUR_W-1:0], last);
		n_sent++;
	endtask

	task automatic send_shaped(input sym_kind_t kind, input logic last);
		int mark;
		int space;
		int r;
		space = pick(0, MAX_DUR);
		case (kind)
			SYM_LEADER: begin
				mark  = pick(int'(w_leader_min) + 1, int'(w_leader_max) - 1);
				space = pick(2000, 5000);
			end
			SYM_NOT_LEADER: begin
				mark = $urandom_range(1, 0) ? pick(0, int'(w_leader_min))
					: pick(int'(w_leader_max), MAX_DUR);
			end
			SYM_ZERO: begin
				mark  = pick(int'(w_mark_min), int'(w_mark_max));
				space = pick(int'(w_space_min),
					(w_one_thr > w_space_min) ? int'(w_one_thr) : int'(w_space_min));
			end
			SYM_ONE: begin
				mark  = pick(int'(w_mark_min), int'(w_mark_max));
				space = pick((int'(w_one_thr) + 1 > int'(w_space_min)) ?
					int'(w_one_thr) + 1 : int'(w_space_min), MAX_DUR);
			end
			SYM_BREAK: begin
				r = $urandom_range(2, 0);
				if (r == 0) begin
					mark = pick(0, int'(w_mark_min) - 1);
				end else if (r == 1) begin
					mark = pick(int'(w_mark_max) + 1, MAX_DUR);
				end else begin
					mark  = pick(int'(w_mark_min), int'(w_mark_max));
					space = pick(0, int'(w_space_min) - 1);
				end
			end
			default: mark = pick(0, MAX_DUR);
		endcase
		send_symbol(mark, space, last);
	endtask

	// lead_at < 0 gives a frame of pure noise
	task automatic send_frame(input int len, input int lead_at, input int n_bits);
		sym_kind_t kind;
		for (int i = 0; i < len; i++) begin
			if (lead_at < 0)
				kind = SYM_NOISE;
			else if (i < lead_at)
				kind = SYM_NOT_LEADER;
			else if (i == lead_at)
				kind = SYM_LEADER;
			else if (i <= lead_at + n_bits)
				kind = $urandom_range(1, 0) ? SYM_ONE : SYM_ZERO;
			else if (i == lead_at + n_bits + 1)
				kind = SYM_BREAK;
			else
				kind = SYM_NOISE;
			send_shaped(kind, i == len - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() > 0) @(posedge clk);
		// a frame with no result yet may still sit in the pipeline
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nfd_pkg::CFG_IDX_W-1:0] idx,
		input logic [nfd_pkg::DUR_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			nfd_pkg::CFG_LEADER_MIN:    w_leader_min = data;
			nfd_pkg::CFG_LEADER_MAX:    w_leader_max = data;
			nfd_pkg::CFG_MARK_MIN:      w_mark_min   = data;
			nfd_pkg::CFG_MARK_MAX:      w_mark_max   = data;
			nfd_pkg::CFG_SPACE_MIN:     w_space_min  = data;
			nfd_pkg::CFG_ONE_THRESHOLD: w_one_thr    = data;
			nfd_pkg::CFG_MIN_BITS:      w_min_bits   = data[nfd_pkg::BITS_W-1:0];
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input int lmin, input int lmax, input int mmin,
		input int mmax, input int smin, input int thr, input int mbits);
		logic [nfd_pkg::DUR_W-nfd_pkg::BITS_W-1:0] junk;
		// upper data bits of the min_bits write must be dropped
		junk = (nfd_pkg::DUR_W-nfd_pkg::BITS_W)'($urandom_range(255, 0));
		write_reg(nfd_pkg::CFG_LEADER_MIN, lmin[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_LEADER_MAX, lmax[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_MARK_MIN, mmin[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_MARK_MAX, mmax[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_SPACE_MIN, smin[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_ONE_THRESHOLD, thr[nfd_pkg::DUR_W-1:0]);
		write_reg(nfd_pkg::CFG_MIN_BITS, {junk, mbits[nfd_pkg::BITS_W-1:0]});
	endtask

	task automatic apply_defaults();
		apply_config(int'(nfd_pkg::LEADER_MIN_RST), int'(nfd_pkg::LEADER_MAX_RST),
			int'(nfd_pkg::MARK_MIN_RST), int'(nfd_pkg::MARK_MAX_RST),
			int'(nfd_pkg::SPACE_MIN_RST), int'(nfd_pkg::ONE_THRESHOLD_RST),
			int'(nfd_pkg::MIN_BITS_RST));
	endtask

	function automatic int extreme_dur();
		case ($urandom_range(2, 0))
			0: return 0;
			1: return MAX_DUR;
			default: return $urandom_range(MAX_DUR, 0);
		endcase
	endfunction

	task automatic random_config();
		int lmin;
		int mmin;
		int smin;
		int mbits;
		int r;
		r = $urandom_range(9, 0);
		mbits = ($urandom_range(9, 0) == 0) ? $urandom_range(127, 64) : $urandom_range(40, 0);
		if (r == 0) begin
			apply_defaults();
		end else if (r == 1) begin
			apply_config(extreme_dur(), extreme_dur(), extreme_dur(), extreme_dur(),
				extreme_dur(), extreme_dur(), mbits);
		end else begin
			lmin = $urandom_range(20000, 1000);
			mmin = $urandom_range(1500, 0);
			smin = $urandom_range(1500, 0);
			apply_config(lmin, lmin + $urandom_range(8000, 2), mmin,
				mmin + $urandom_range(3000, 0), smin, smin + $urandom_range(3000, 0), mbits);
		end
	endtask

	task automatic random_frame();
		int len;
		int lead;
		int nb;
		int r;
		r = $urandom_range(99, 0);
		if (r < 8)
			len = $urandom_range(20, 1);
		else if (r < 88)
			len = $urandom_range(60, 21);
		else if (r < 97)
			len = $urandom_range(200, 150);
		else
			len = $urandom_range(300, 250);
		r = $urandom_range(99, 0);
		if (r < 12)
			lead = -1;
		else if (len > 40 && $urandom_range(3, 0) == 0)
			lead = $urandom_range((len < 170) ? len : 170, 0);
		else
			lead = $urandom_range(3, 0);
		case ($urandom_range(3, 0))
			0, 1: nb = 32;
			2:    nb = $urandom_range(70, 0);
			default: nb = $urandom_range(len, 0);
		endcase
		send_frame(len, lead, nb);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_standard_frame();
		logic [31:0] code;
		code = 32'h20DF_10EF;
		send_symbol(9000, 4500, 1'b0);
		for (int i = 31; i >= 0; i--)
			send_symbol(560, code[i] ? 1690 : 560, 1'b0);
		send_symbol(560, 0, 1'b1);
		// repeat code: far too short to count as a frame
		send_symbol(9000, 2250, 1'b0);
		send_symbol(560, 0, 1'b1);
	endtask

	task automatic test_frame_lengths();
		send_frame(1, 0, 0);
		send_frame(20, 0, 19);
		send_frame(21, 0, 20);
		send_frame(193, 0, 32);
		// counter saturates at 255
		send_frame(260, 0, 32);
	endtask

	task automatic test_leader_placement();
		drain();
		write_reg(nfd_pkg::CFG_MIN_BITS, 15'd8);
		send_frame(30, 13, 16);
		send_frame(30, 14, 16);
		// leader near the kept limit, in the longest frame that counts
		send_frame(192, 143, 16);
		send_frame(192, 144, 15);
		// leader beyond the kept limit
		send_frame(166, 165, 4);
		// more than a code word of bits
		send_frame(72, 0, 70);
		drain();
		write_reg(nfd_pkg::CFG_MIN_BITS, nfd_pkg::DUR_W'(nfd_pkg::MIN_BITS_RST));
	endtask

	task automatic test_config_extremes();
		drain();
		apply_config(0, 0, 0, 0, 0, 0, 0);
		send_frame(25, 0, 20);
		drain();
		apply_config(0, MAX_DUR, 0, MAX_DUR, 0, 0, 0);
		send_frame(40, 0, 30);
		send_frame(30, -1, 0);
		drain();
		// no bit can pass, so only min_bits of zero gives NEC
		apply_config(0, MAX_DUR, MAX_DUR, 0, MAX_DUR, MAX_DUR, 0);
		send_frame(21, 0, 0);
		drain();
		apply_config(7000, 11000, 0, MAX_DUR, 0, MAX_DUR, 64);
		send_frame(66, 0, 64);
		drain();
		write_reg(nfd_pkg::CFG_MIN_BITS, 15'h7FFF);
		write_reg(CFG_SPARE, nfd_pkg::DUR_W'($urandom_range(MAX_DUR, 0)));
		send_frame(66, 0, 64);
		drain();
		restore_defaults();
		apply_defaults();
	endtask

	task automatic test_backpressure();
		drain();
		tx_idle_en = 1'b0;
		-> hold_start;
		repeat (12) send_frame(1, 0, 0);
		send_frame(25, 0, 24);
		drain();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_frames();
		int syms_at;
		int count;
		syms_at = n_sent;
		count   = 0;
		while (n_sent - syms_at < RAND_SYMBOLS) begin
			if (count % 2 == 0) begin
				drain();
				random_config();
			end
			tx_idle_en = ($urandom_range(3, 0) != 0);
			rx_idle_en = ($urandom_range(3, 0) != 0);
			random_frame();
			count++;
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		mark_duration  <= '0;
		space_duration <= '0;
		last_symbol    <= 1'b0;
		restore_defaults();
		clear_frame();
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_standard_frame();
		test_frame_lengths();
		test_leader_placement();
		test_config_extremes();
		test_backpressure();
		test_random_frames();

		drain();
		if (frames_due.size() != 0)
			n_mismatch++;
		if (n_mismatch == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
